// ----- rtl/scanline_instr_decoder_core_macros.svh -----
// assertion macros for the scanline instruction decoder
`ifndef SCANLINE_INSTR_DECODER_CORE_MACROS_SVH
`define SCANLINE_INSTR_DECODER_CORE_MACROS_SVH

// same-cycle implication, idle during reset
`define SID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define SID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after reset is seen
`define SID_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sid_pkg.sv -----
`timescale 1ns / 1ps

package sid_pkg;

    localparam int TypeCount = 32;

    typedef enum logic [2:0] {
        ENC_SHORT_LIST,
        ENC_SHORT_COPY,
        ENC_LONG_LIST8,
        ENC_SHORT_BITMAP,
        ENC_LONG_LIST16,
        ENC_LONG_COPY,
        ENC_LONG_BITMAP
    } t_enc;

    typedef enum logic [1:0] {
        CMD_LIST8,
        CMD_LIST16,
        CMD_COPY,
        CMD_BITMAP
    } t_cmd;

    localparam t_enc ENC_TABLE [0:TypeCount-1] = '{
        ENC_SHORT_COPY, ENC_SHORT_COPY, ENC_SHORT_COPY, ENC_SHORT_COPY,
        ENC_SHORT_COPY, ENC_SHORT_COPY, ENC_SHORT_COPY, ENC_SHORT_COPY,
        ENC_SHORT_COPY, ENC_SHORT_COPY, ENC_SHORT_COPY, ENC_SHORT_COPY,
        ENC_SHORT_BITMAP, ENC_SHORT_BITMAP, ENC_SHORT_BITMAP, ENC_SHORT_BITMAP,
        ENC_SHORT_LIST, ENC_SHORT_LIST, ENC_SHORT_LIST, ENC_LONG_LIST8,
        ENC_SHORT_LIST, ENC_SHORT_LIST, ENC_SHORT_LIST, ENC_SHORT_LIST,
        ENC_LONG_COPY, ENC_LONG_COPY, ENC_LONG_COPY, ENC_LONG_BITMAP,
        ENC_LONG_LIST16, ENC_LONG_LIST16, ENC_LONG_LIST16, ENC_LONG_LIST16
    };

    localparam int CntW  = 12;
    localparam int StpW  = 3;
    localparam int PrmW  = 11;
    localparam int OffW  = 2;
    localparam int LenW  = 13;
    localparam int MulAW = 11;
    localparam int BaseW = 3;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        t_enc       enc;
    } t_cls;

    typedef struct packed {
        t_cmd             cmd;
        logic [CntW-1:0]  cnt;
        logic [StpW-1:0]  stp;
        logic [PrmW-1:0]  prm;
        logic [OffW-1:0]  off;
        logic [MulAW-1:0] mul_a;
        logic [StpW-1:0]  mul_b;
        logic [BaseW-1:0] base_len;
    } t_fld;

    typedef struct packed {
        t_cmd             cmd;
        logic [CntW-1:0]  cnt;
        logic [StpW-1:0]  stp;
        logic [PrmW-1:0]  prm;
        logic [OffW-1:0]  off;
        logic [LenW-1:0]  prod;
        logic [BaseW-1:0] base_len;
    } t_prd;

    typedef struct packed {
        t_cmd            cmd;
        logic [CntW-1:0] cnt;
        logic [StpW-1:0] stp;
        logic [PrmW-1:0] prm;
        logic [OffW-1:0] off;
        logic [LenW-1:0] len;
    } t_res;

endpackage

// ----- rtl/scanline_instr_decoder_core.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake          | payload
// request  | in        | i_valid / o_ready  | i_first_byte, i_second_byte, i_third_byte
// result   | out       | o_valid / i_ready  | o_command, o_repeat_count, o_step_value,
//          |           |                    | o_parameter_res, o_list_offset, o_length_bytes
//
// one request per cycle while no stage is blocked, one result per request
// stages: type table lookup, field extraction, stride multiply, length add
// synchronous active-low reset empties all four stages
// each stage holds while full and blocked; a stalled result keeps its stage and
// earlier stages still fill any empty slots behind it

module scanline_instr_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_first_byte,
    input  logic [7:0]  i_second_byte,
    input  logic [7:0]  i_third_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_command,
    output logic [11:0] o_repeat_count,
    output logic [2:0]  o_step_value,
    output logic [10:0] o_parameter_res,
    output logic [1:0]  o_list_offset,
    output logic [12:0] o_length_bytes
);
    import sid_pkg::*;

    logic w_cls_valid;
    logic w_cls_ready;
    t_cls w_cls;
    logic w_fld_valid;
    logic w_fld_ready;
    t_fld w_fld;
    t_res w_res;

    sid_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_first_byte  (i_first_byte),
        .i_second_byte (i_second_byte),
        .i_third_byte  (i_third_byte),
        .o_valid       (w_cls_valid),
        .i_ready       (w_cls_ready),
        .o_cls         (w_cls)
    );

    sid_extract u_extract (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cls_valid),
        .o_ready (w_cls_ready),
        .i_cls   (w_cls),
        .o_valid (w_fld_valid),
        .i_ready (w_fld_ready),
        .o_fld   (w_fld)
    );

    sid_length u_length (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fld_valid),
        .o_ready (w_fld_ready),
        .i_fld   (w_fld),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_res)
    );

    assign o_command       = w_res.cmd;
    assign o_repeat_count  = w_res.cnt;
    assign o_step_value    = w_res.stp;
    assign o_parameter_res = w_res.prm;
    assign o_list_offset   = w_res.off;
    assign o_length_bytes  = w_res.len;

endmodule

// ----- rtl/sid_classify.sv -----
`timescale 1ns / 1ps

module sid_classify (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_first_byte,
    input  logic [7:0]    i_second_byte,
    input  logic [7:0]    i_third_byte,
    output logic          o_valid,
    input  logic          i_ready,
    output sid_pkg::t_cls o_cls
);
    import sid_pkg::*;

    logic r_valid;
    t_cls r_cls;
    t_cls n_cls;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_cls.b0  = i_first_byte;
        n_cls.b1  = i_second_byte;
        n_cls.b2  = i_third_byte;
        n_cls.enc = ENC_TABLE[i_first_byte[7:3]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_cls <= n_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

// ----- rtl/sid_extract.sv -----
`timescale 1ns / 1ps

module sid_extract (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sid_pkg::t_cls i_cls,
    output logic          o_valid,
    input  logic          i_ready,
    output sid_pkg::t_fld o_fld
);
    import sid_pkg::*;

    logic r_valid;
    t_fld r_fld;
    t_fld n_fld;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_fld          = '0;
        n_fld.cmd      = CMD_BITMAP;
        n_fld.base_len = BaseW'(1);
        unique case (i_cls.enc)
            ENC_SHORT_LIST: begin
                n_fld.cmd      = CMD_LIST8;
                n_fld.cnt      = CntW'(i_cls.b0[4:0]) + CntW'(1);
                n_fld.stp      = StpW'(i_cls.b0[5]);
                n_fld.off      = OffW'(1);
                n_fld.mul_a    = MulAW'(i_cls.b0[4:0]);
                n_fld.mul_b    = StpW'(i_cls.b0[5]);
                n_fld.base_len = BaseW'(2);
            end
            ENC_SHORT_COPY: begin
                n_fld.cmd      = CMD_COPY;
                n_fld.cnt      = CntW'(i_cls.b0[4:0]) + CntW'(1);
                n_fld.stp      = StpW'(i_cls.b0[6:5]);
                n_fld.prm      = PrmW'(i_cls.b1);
                n_fld.base_len = BaseW'(2);
            end
            ENC_LONG_LIST8: begin
                n_fld.cmd      = CMD_LIST8;
                n_fld.cnt      = CntW'({i_cls.b0[2:0], i_cls.b1}) + CntW'(1);
                n_fld.stp      = StpW'(1);
                n_fld.off      = OffW'(2);
                n_fld.mul_a    = MulAW'({i_cls.b0[2:0], i_cls.b1});
                n_fld.mul_b    = StpW'(1);
                n_fld.base_len = BaseW'(3);
            end
            ENC_SHORT_BITMAP: begin
                n_fld.cmd      = CMD_BITMAP;
                n_fld.prm      = PrmW'(i_cls.b0[4:0]);
                n_fld.base_len = BaseW'(1);
            end
            ENC_LONG_LIST16: begin
                n_fld.cmd      = CMD_LIST16;
                n_fld.cnt      = CntW'({i_cls.b0[1:0], i_cls.b1}) + CntW'(1);
                n_fld.stp      = i_cls.b0[4:2];
                n_fld.off      = OffW'(2);
                n_fld.mul_a    = MulAW'({i_cls.b0[1:0], i_cls.b1});
                n_fld.mul_b    = i_cls.b0[4:2];
                n_fld.base_len = BaseW'(4);
            end
            ENC_LONG_COPY: begin
                n_fld.cmd      = CMD_COPY;
                n_fld.cnt      = CntW'(i_cls.b2) + CntW'(1);
                n_fld.stp      = StpW'(i_cls.b0[4:3]);
                n_fld.prm      = {i_cls.b0[2:0], i_cls.b1};
                n_fld.base_len = BaseW'(3);
            end
            default: begin
                n_fld.cmd      = CMD_BITMAP;
                n_fld.prm      = PrmW'(i_cls.b1);
                n_fld.base_len = BaseW'(2);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_fld <= n_fld;
        end
    end

    assign o_valid = r_valid;
    assign o_fld   = r_fld;

endmodule

// ----- rtl/sid_length.sv -----
`timescale 1ns / 1ps

module sid_length (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sid_pkg::t_fld i_fld,
    output logic          o_valid,
    input  logic          i_ready,
    output sid_pkg::t_res o_res
);
    import sid_pkg::*;

    logic                  r_a_valid;
    t_prd                  r_a;
    t_prd                  n_a;
    logic                  r_b_valid;
    t_res                  r_b;
    t_res                  n_b;
    logic                  w_ready_a;
    logic                  w_ready_b;
    logic [LenW-1:0]       w_prod;

    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    // gap list size: entry count less one times stride
    assign w_prod = LenW'(i_fld.mul_a) * LenW'(i_fld.mul_b);

    always_comb begin
        n_a.cmd      = i_fld.cmd;
        n_a.cnt      = i_fld.cnt;
        n_a.stp      = i_fld.stp;
        n_a.prm      = i_fld.prm;
        n_a.off      = i_fld.off;
        n_a.prod     = w_prod;
        n_a.base_len = i_fld.base_len;
    end

    always_comb begin
        n_b.cmd = r_a.cmd;
        n_b.cnt = r_a.cnt;
        n_b.stp = r_a.stp;
        n_b.prm = r_a.prm;
        n_b.off = r_a.off;
        n_b.len = r_a.prod + LenW'(r_a.base_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_a_valid <= i_valid;
            end
            if (w_ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
        if (i_valid && w_ready_a) begin
            r_a <= n_a;
        end
        if (r_a_valid && w_ready_b) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_res   = r_b;

endmodule

// ----- rtl/sid_checker.sv -----
`timescale 1ns / 1ps
`include "scanline_instr_decoder_core_macros.svh"

module sid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_command,
    input logic [11:0] o_repeat_count,
    input logic [2:0]  o_step_value,
    input logic [10:0] o_parameter_res,
    input logic [1:0]  o_list_offset,
    input logic [12:0] o_length_bytes
);
    import sid_pkg::*;

    logic w_stall;
    logic w_bmp;
    logic w_list;
    logic w_copy;
    logic w_bmp_ok;
    logic w_list_ok;
    logic w_copy_ok;

    assign w_stall   = o_valid && !i_ready;
    assign w_bmp     = o_valid && o_command == CMD_BITMAP;
    assign w_list    = o_valid && (o_command == CMD_LIST8 || o_command == CMD_LIST16);
    assign w_copy    = o_valid && o_command == CMD_COPY;
    assign w_bmp_ok  = o_repeat_count == 12'd0 && o_step_value == 3'd0 && o_list_offset == 2'd0;
    assign w_list_ok = o_parameter_res == 11'd0 && o_list_offset != 2'd0
                       && o_repeat_count != 12'd0;
    assign w_copy_ok = (o_length_bytes == 13'd2 || o_length_bytes == 13'd3)
                       && o_repeat_count != 12'd0;

    `SID_ASSERT_RST(a_rst_empty, !o_valid, "result valid right after reset")

    `SID_ASSERT_NEXT(a_stall_hold, w_stall, o_valid && $stable(o_length_bytes), "stalled result changed")

    `SID_ASSERT_NOW(a_bitmap_fields, w_bmp, w_bmp_ok, "bitmap switch with list or count fields")

    `SID_ASSERT_NOW(a_list_fields, w_list, w_list_ok, "list result with bad parameter offset or count")

    `SID_ASSERT_NOW(a_copy_len, w_copy, w_copy_ok, "scan copy with bad length or count")

endmodule

bind scanline_instr_decoder_core sid_checker u_sid_checker (.*);

// ----- sim/scanline_instr_decoder_core_test.sv -----
`timescale 1ns / 1ps

module scanline_instr_decoder_core_test;
    import sid_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_first_byte = 8'd0;
    logic [7:0]  i_second_byte = 8'd0;
    logic [7:0]  i_third_byte = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_command;
    logic [11:0] o_repeat_count;
    logic [2:0]  o_step_value;
    logic [10:0] o_parameter_res;
    logic [1:0]  o_list_offset;
    logic [12:0] o_length_bytes;

    scanline_instr_decoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_first_byte    (i_first_byte),
        .i_second_byte   (i_second_byte),
        .i_third_byte    (i_third_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_command       (o_command),
        .o_repeat_count  (o_repeat_count),
        .o_step_value    (o_step_value),
        .o_parameter_res (o_parameter_res),
        .o_list_offset   (o_list_offset),
        .o_length_bytes  (o_length_bytes)
    );

    t_res pending_decodes [$];
    int   mismatch_count = 0;
    int   error_count = 0;
    int   decoded_count = 0;
    int   request_count = 0;
    int   cycle_count = 0;
    int   hold_off_request = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    int   enc_seen [7];

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // own classification of the type bits
    function automatic t_enc classify_instruction(input logic [7:0] b0);
        if (b0 < 8'd96) return ENC_SHORT_COPY;
        if (b0 < 8'd128) return ENC_SHORT_BITMAP;
        if (b0[7:3] == 5'd19) return ENC_LONG_LIST8;
        if (b0 < 8'd192) return ENC_SHORT_LIST;
        if (b0 < 8'd216) return ENC_LONG_COPY;
        if (b0 < 8'd224) return ENC_LONG_BITMAP;
        return ENC_LONG_LIST16;
    endfunction

    function automatic t_res decode_instruction(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2);
        t_res r;
        int   cnt;
        int   stp;
        int   len;
        r = '0;
        cnt = 0;
        stp = 0;
        len = 1;
        case (classify_instruction(b0))
            ENC_SHORT_COPY: begin
                r.cmd = CMD_COPY;
                cnt = b0[4:0] + 1;
                stp = b0[6:5];
                r.prm = {3'd0, b1};
                len = 2;
            end
            ENC_SHORT_BITMAP: begin
                r.cmd = CMD_BITMAP;
                r.prm = {6'd0, b0[4:0]};
                len = 1;
            end
            ENC_SHORT_LIST: begin
                r.cmd = CMD_LIST8;
                cnt = b0[4:0] + 1;
                stp = b0[5];
                r.off = 2'd1;
                len = 2 + (cnt - 1) * stp;
            end
            ENC_LONG_LIST8: begin
                r.cmd = CMD_LIST8;
                cnt = {b0[2:0], b1} + 1;
                stp = 1;
                r.off = 2'd2;
                len = 2 + cnt;
            end
            ENC_LONG_COPY: begin
                r.cmd = CMD_COPY;
                cnt = b2 + 1;
                stp = b0[4:3];
                r.prm = {b0[2:0], b1};
                len = 3;
            end
            ENC_LONG_BITMAP: begin
                r.cmd = CMD_BITMAP;
                r.prm = {3'd0, b1};
                len = 2;
            end
            default: begin
                r.cmd = CMD_LIST16;
                cnt = {b0[1:0], b1} + 1;
                stp = b0[4:2];
                r.off = 2'd2;
                len = 4 + (cnt - 1) * stp;
            end
        endcase
        r.cnt = cnt[CntW-1:0];
        r.stp = stp[StpW-1:0];
        r.len = len[LenW-1:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_decodes.size());
            $display("simulation failed");
            $finish;
        end
    end

    // result side ready, with random stalls and a requested long hold-off
    int stall_left = 0;
    int ready_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_off_request > 0) begin
                stall_left = hold_off_request;
                hold_off_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                i_ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 99) < 15) begin
                ready_gap = pick_gap();
                i_ready <= (ready_gap == 0);
                if (ready_gap > 0) ready_gap--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            got.cmd = t_cmd'(o_command);
            got.cnt = o_repeat_count;
            got.stp = o_step_value;
            got.prm = o_parameter_res;
            got.off = o_list_offset;
            got.len = o_length_bytes;
            if (pending_decodes.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: cmd %0d cnt %0d stp %0d prm %0d off %0d len %0d",
                             got.cmd, got.cnt, got.stp, got.prm, got.off, got.len);
            end else begin
                want = pending_decodes.pop_front();
                decoded_count++;
                if (got != want) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at result %0d:", decoded_count);
                        $display("  expected cmd %0d cnt %0d stp %0d prm %0d off %0d len %0d",
                                 want.cmd, want.cnt, want.stp, want.prm, want.off, want.len);
                        $display("  actual   cmd %0d cnt %0d stp %0d prm %0d off %0d len %0d",
                                 got.cmd, got.cnt, got.stp, got.prm, got.off, got.len);
                    end
                end
            end
        end
    end

    task automatic send_request(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_byte <= b0;
        i_second_byte <= b1;
        i_third_byte <= b2;
        do @(posedge i_clk); while (!o_ready);
        pending_decodes.push_back(decode_instruction(b0, b1, b2));
        enc_seen[classify_instruction(b0)]++;
        request_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_decodes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(8'd0, 8'd0, 8'd0);
        send_request(8'd95, 8'd255, 8'd255);
        send_request(8'd64, 8'd170, 8'd85);
        send_request(8'd96, 8'd255, 8'd255);
        send_request(8'd127, 8'd0, 8'd255);
        send_request(8'd128, 8'd255, 8'd255);
        send_request(8'd151, 8'd0, 8'd0);
        send_request(8'd160, 8'd0, 8'd255);
        send_request(8'd191, 8'd255, 8'd0);
        send_request(8'd152, 8'd0, 8'd255);
        send_request(8'd159, 8'd255, 8'd0);
        send_request(8'd192, 8'd0, 8'd0);
        send_request(8'd215, 8'd255, 8'd255);
        send_request(8'd200, 8'd1, 8'd128);
        send_request(8'd216, 8'd0, 8'd255);
        send_request(8'd223, 8'd255, 8'd0);
        send_request(8'd224, 8'd0, 8'd255);
        send_request(8'd255, 8'd255, 8'd255);
        send_request(8'd228, 8'd5, 8'd0);
        send_request(8'd227, 8'd170, 8'd0);
        wait_drained();
    endtask

    task automatic test_random_bytes(input int count);
        repeat (count) send_request(8'($urandom), 8'($urandom), 8'($urandom));
        wait_drained();
    endtask

    // pick an encoding first so the narrow ones get their share
    task automatic test_random_encodings(input int count);
        logic [7:0] b0;
        repeat (count) begin
            case ($urandom_range(0, 6))
                0: b0 = 8'($urandom_range(0, 95));
                1: b0 = 8'($urandom_range(96, 127));
                2: b0 = 8'($urandom_range(152, 159));
                3: b0 = $urandom_range(0, 1) ? 8'($urandom_range(128, 151))
                                             : 8'($urandom_range(160, 191));
                4: b0 = 8'($urandom_range(192, 215));
                5: b0 = 8'($urandom_range(216, 223));
                default: b0 = 8'($urandom_range(224, 255));
            endcase
            send_request(b0, 8'($urandom), 8'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        hold_off_request = 200;
        repeat (40) send_request(8'($urandom), 8'($urandom), 8'($urandom));
        tx_idle = 1'b1;
        wait_drained();
    endtask

    task automatic test_full_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (60) send_request(8'($urandom), 8'($urandom), 8'($urandom));
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_bytes(130);
        test_random_encodings(200);
        test_backpressure();
        test_full_rate();
        test_random_bytes(50);
        repeat (DrainCycles) @(posedge i_clk);
        if (pending_decodes.size() != 0) begin
            error_count++;
            $display("%0d results never arrived", pending_decodes.size());
        end
        $display("%0d requests decoded, %0d results checked, %0d mismatches", request_count,
                 decoded_count, mismatch_count);
        $display("per encoding: scopy %0d sbmp %0d slist %0d list8 %0d",
                 enc_seen[ENC_SHORT_COPY], enc_seen[ENC_SHORT_BITMAP], enc_seen[ENC_SHORT_LIST],
                 enc_seen[ENC_LONG_LIST8]);
        $display("              list16 %0d lcopy %0d lbmp %0d",
                 enc_seen[ENC_LONG_LIST16], enc_seen[ENC_LONG_COPY], enc_seen[ENC_LONG_BITMAP]);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sid_pkg.sv
rtl/sid_classify.sv
rtl/sid_extract.sv
rtl/sid_length.sv
rtl/scanline_instr_decoder_core.sv
rtl/sid_checker.sv
sim/scanline_instr_decoder_core_test.sv
